// ===== rtl/core/euler_xyz_vector_rotation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euler XYZ vector rotation block
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef EULER_XYZ_VECTOR_ROTATION_ASSERT_SVH
`define EULER_XYZ_VECTOR_ROTATION_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ERV_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("erv assertion failed");

// Next-cycle implication
`define ERV_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("erv assertion failed");

`else

`define ERV_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define ERV_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

// ===== rtl/core/erv_pkg.sv =====
// ----------------------------------------------------------------------------
// erv_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package erv_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int GUARD_BITS   = 8;

	// Internal coordinate: input plus guard fraction plus headroom for CORDIC growth
	localparam int ACC_WIDTH  = COORD_WIDTH + GUARD_BITS + 4;
	localparam int ZRES_WIDTH = 32;
	localparam int ANGLE_PAD  = 32 - ANGLE_WIDTH;
	localparam int SIDE_WIDTH = 2 * ANGLE_WIDTH;

	// Gain compensation: floor(x * GAIN_INV / 2^GAIN_FRAC)
	localparam int GAIN_WIDTH = 30;
	localparam int GAIN_FRAC  = 30;
	localparam logic [GAIN_WIDTH-1:0] GAIN_INV = GAIN_WIDTH'(652032874);

	// Split multiply of the gain into two partial products
	localparam int SPLIT_W = ACC_WIDTH / 2;
	localparam int HI_W    = ACC_WIDTH - SPLIT_W;
	localparam int PH_W    = HI_W + GAIN_WIDTH + 1;
	localparam int PL_W    = SPLIT_W + GAIN_WIDTH;
	localparam int TOT_W   = PH_W + SPLIT_W + 1;

	// Pipeline depth of one plane rotation: pre-rotation, micro-rotations, gain
	localparam int PLANE_LATENCY = 1 + CORDIC_STEPS + 2;

	typedef logic signed [ACC_WIDTH-1:0]  acc_t;
	typedef logic signed [ZRES_WIDTH-1:0] zres_t;
	typedef logic [ANGLE_WIDTH-1:0]       angle_t;
	typedef logic [SIDE_WIDTH-1:0]        side_t;
	typedef logic [1:0]                   quad_t;

	localparam quad_t QUAD_0 = 2'd0;
	localparam quad_t QUAD_1 = 2'd1;
	localparam quad_t QUAD_2 = 2'd2;
	localparam quad_t QUAD_3 = 2'd3;

	// atan(2^-i) at 2^32 units per turn
	function automatic zres_t atan_angle(input int i);
		zres_t r;
		case (i)
			0:  r = 32'sd536870912;
			1:  r = 32'sd316933406;
			2:  r = 32'sd167458907;
			3:  r = 32'sd85004756;
			4:  r = 32'sd42667331;
			5:  r = 32'sd21354465;
			6:  r = 32'sd10679838;
			7:  r = 32'sd5340245;
			8:  r = 32'sd2670163;
			9:  r = 32'sd1335087;
			10: r = 32'sd667544;
			11: r = 32'sd333772;
			12: r = 32'sd166886;
			13: r = 32'sd83443;
			14: r = 32'sd41722;
			15: r = 32'sd20861;
			16: r = 32'sd10430;
			17: r = 32'sd5215;
			18: r = 32'sd2608;
			19: r = 32'sd1304;
			20: r = 32'sd652;
			21: r = 32'sd326;
			22: r = 32'sd163;
			23: r = 32'sd81;
			24: r = 32'sd41;
			25: r = 32'sd20;
			26: r = 32'sd10;
			27: r = 32'sd5;
			28: r = 32'sd3;
			29: r = 32'sd1;
			30: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/erv_gain.sv =====
// ----------------------------------------------------------------------------
// erv_gain
// Two-stage CORDIC gain compensation of a (u, v) pair, carrying w and side.
// ----------------------------------------------------------------------------
`default_nettype none

module erv_gain (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_i,
	input  wire erv_pkg::acc_t  u_i,
	input  wire erv_pkg::acc_t  v_i,
	input  wire erv_pkg::acc_t  w_i,
	input  wire erv_pkg::side_t side_i,
	output logic                vld_o,
	output erv_pkg::acc_t       u_o,
	output erv_pkg::acc_t       v_o,
	output erv_pkg::acc_t       w_o,
	output erv_pkg::side_t      side_o
);

	logic signed [erv_pkg::GAIN_WIDTH:0] gain_s;

	logic signed [erv_pkg::PH_W-1:0] ph_u_s1, ph_v_s1;
	logic [erv_pkg::PL_W-1:0]        pl_u_s1, pl_v_s1;
	erv_pkg::acc_t                   w_s1;
	erv_pkg::side_t                  side_s1;
	logic                            vld_s1;

	logic signed [erv_pkg::TOT_W-1:0] tot_u, tot_v;

	assign gain_s = {1'b0, erv_pkg::GAIN_INV};

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

	// Stage 1: partial products of the signed high half and the unsigned low half
	always_ff @(posedge clk) begin
		if (en) begin
			ph_u_s1 <= $signed(u_i[erv_pkg::ACC_WIDTH-1:erv_pkg::SPLIT_W]) * gain_s;
			ph_v_s1 <= $signed(v_i[erv_pkg::ACC_WIDTH-1:erv_pkg::SPLIT_W]) * gain_s;
			pl_u_s1 <= u_i[erv_pkg::SPLIT_W-1:0] * erv_pkg::GAIN_INV;
			pl_v_s1 <= v_i[erv_pkg::SPLIT_W-1:0] * erv_pkg::GAIN_INV;
			w_s1    <= w_i;
			side_s1 <= side_i;
		end
	end

	// Recombine; dropping the low bits floors the scaled value
	assign tot_u = {{(erv_pkg::TOT_W - erv_pkg::PH_W - erv_pkg::SPLIT_W){ph_u_s1[erv_pkg::PH_W-1]}},
		ph_u_s1, {erv_pkg::SPLIT_W{1'b0}}} + {{(erv_pkg::TOT_W - erv_pkg::PL_W){1'b0}}, pl_u_s1};
	assign tot_v = {{(erv_pkg::TOT_W - erv_pkg::PH_W - erv_pkg::SPLIT_W){ph_v_s1[erv_pkg::PH_W-1]}},
		ph_v_s1, {erv_pkg::SPLIT_W{1'b0}}} + {{(erv_pkg::TOT_W - erv_pkg::PL_W){1'b0}}, pl_v_s1};

	// Stage 2: register the compensated pair
	always_ff @(posedge clk) begin
		if (en) begin
			u_o    <= tot_u[erv_pkg::GAIN_FRAC + erv_pkg::ACC_WIDTH - 1:erv_pkg::GAIN_FRAC];
			v_o    <= tot_v[erv_pkg::GAIN_FRAC + erv_pkg::ACC_WIDTH - 1:erv_pkg::GAIN_FRAC];
			w_o    <= w_s1;
			side_o <= side_s1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/erv_plane.sv =====
// ----------------------------------------------------------------------------
// erv_plane
// Pipelined rotation of one coordinate plane: quarter-turn pre-rotation,
// one CORDIC micro-rotation per stage, then gain compensation.
// ----------------------------------------------------------------------------
`default_nettype none

module erv_plane (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vld_i,
	input  wire erv_pkg::acc_t   u_i,
	input  wire erv_pkg::acc_t   v_i,
	input  wire erv_pkg::acc_t   w_i,
	input  wire erv_pkg::angle_t angle_i,
	input  wire erv_pkg::side_t  side_i,
	output logic                 vld_o,
	output erv_pkg::acc_t        u_o,
	output erv_pkg::acc_t        v_o,
	output erv_pkg::acc_t        w_o,
	output erv_pkg::side_t       side_o
);

	logic [31:0]       a32;
	logic [31:0]       a_round;
	erv_pkg::quad_t    quad;
	logic [31:0]       rem;
	erv_pkg::acc_t     pre_u, pre_v;

	erv_pkg::acc_t     u_s    [0:erv_pkg::CORDIC_STEPS];
	erv_pkg::acc_t     v_s    [0:erv_pkg::CORDIC_STEPS];
	erv_pkg::acc_t     w_s    [0:erv_pkg::CORDIC_STEPS];
	erv_pkg::zres_t    z_s    [0:erv_pkg::CORDIC_STEPS-1];
	erv_pkg::side_t    side_s [0:erv_pkg::CORDIC_STEPS];
	logic              vld_s  [0:erv_pkg::CORDIC_STEPS];

	// Scale angle to 32 bits per turn and pick the nearest quadrant
	assign a32     = {angle_i, {erv_pkg::ANGLE_PAD{1'b0}}};
	assign a_round = a32 + 32'h2000_0000;
	assign quad    = a_round[31:30];
	assign rem     = a32 - {quad, 30'd0};

	// Exact quarter-turn rotation
	always_comb begin
		case (quad)
			erv_pkg::QUAD_1: begin
				pre_u = -v_i;
				pre_v = u_i;
			end
			erv_pkg::QUAD_2: begin
				pre_u = -u_i;
				pre_v = -v_i;
			end
			erv_pkg::QUAD_3: begin
				pre_u = v_i;
				pre_v = -u_i;
			end
			default: begin
				pre_u = u_i;
				pre_v = v_i;
			end
		endcase
	end

	// Pre-rotation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s[0]    <= pre_u;
			v_s[0]    <= pre_v;
			w_s[0]    <= w_i;
			z_s[0]    <= $signed(rem);
			side_s[0] <= side_i;
		end
	end

	// One micro-rotation per stage
	for (genvar k = 0; k < erv_pkg::CORDIC_STEPS; k++) begin : g_step
		erv_pkg::acc_t du, dv;
		logic          pos;

		assign du  = v_s[k] >>> k;
		assign dv  = u_s[k] >>> k;
		assign pos = !z_s[k][erv_pkg::ZRES_WIDTH-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				u_s[k+1]    <= pos ? (u_s[k] - du) : (u_s[k] + du);
				v_s[k+1]    <= pos ? (v_s[k] + dv) : (v_s[k] - dv);
				w_s[k+1]    <= w_s[k];
				side_s[k+1] <= side_s[k];
			end
		end

		// Residual angle is not needed after the last step
		if (k < erv_pkg::CORDIC_STEPS - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					z_s[k+1] <= pos ? (z_s[k] - erv_pkg::atan_angle(k))
						: (z_s[k] + erv_pkg::atan_angle(k));
				end
			end
		end
	end

	erv_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s[erv_pkg::CORDIC_STEPS]),
		.u_i    (u_s[erv_pkg::CORDIC_STEPS]),
		.v_i    (v_s[erv_pkg::CORDIC_STEPS]),
		.w_i    (w_s[erv_pkg::CORDIC_STEPS]),
		.side_i (side_s[erv_pkg::CORDIC_STEPS]),
		.vld_o  (vld_o),
		.u_o    (u_o),
		.v_o    (v_o),
		.w_o    (w_o),
		.side_o (side_o)
	);

endmodule

`default_nettype wire

// ===== rtl/core/erv_round_sat.sv =====
// ----------------------------------------------------------------------------
// erv_round_sat
// Output register: drop guard bits with round-half-up and clip to range.
// ----------------------------------------------------------------------------
`default_nettype none

module erv_round_sat (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              vld_i,
	input  wire erv_pkg::acc_t                     x_i,
	input  wire erv_pkg::acc_t                     y_i,
	input  wire erv_pkg::acc_t                     z_i,
	output logic                                   vld_o,
	output logic signed [erv_pkg::COORD_WIDTH-1:0] x_o,
	output logic signed [erv_pkg::COORD_WIDTH-1:0] y_o,
	output logic signed [erv_pkg::COORD_WIDTH-1:0] z_o,
	output logic                                   sat_o
);

	localparam erv_pkg::acc_t HALF = erv_pkg::acc_t'(1) <<< (erv_pkg::GUARD_BITS - 1);
	localparam erv_pkg::acc_t MAXV = (erv_pkg::acc_t'(1) <<< (erv_pkg::COORD_WIDTH - 1)) - 1;
	localparam erv_pkg::acc_t MINV = -MAXV - 1;

	erv_pkg::acc_t rx, ry, rz;
	logic          hx, lx, hy, ly, hz, lz;

	// Round half up
	assign rx = (x_i + HALF) >>> erv_pkg::GUARD_BITS;
	assign ry = (y_i + HALF) >>> erv_pkg::GUARD_BITS;
	assign rz = (z_i + HALF) >>> erv_pkg::GUARD_BITS;

	assign hx = rx > MAXV;
	assign lx = rx < MINV;
	assign hy = ry > MAXV;
	assign ly = ry < MINV;
	assign hz = rz > MAXV;
	assign lz = rz < MINV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// Clip and flag
	always_ff @(posedge clk) begin
		if (en) begin
			x_o   <= hx ? MAXV[erv_pkg::COORD_WIDTH-1:0] : lx ? MINV[erv_pkg::COORD_WIDTH-1:0]
				: rx[erv_pkg::COORD_WIDTH-1:0];
			y_o   <= hy ? MAXV[erv_pkg::COORD_WIDTH-1:0] : ly ? MINV[erv_pkg::COORD_WIDTH-1:0]
				: ry[erv_pkg::COORD_WIDTH-1:0];
			z_o   <= hz ? MAXV[erv_pkg::COORD_WIDTH-1:0] : lz ? MINV[erv_pkg::COORD_WIDTH-1:0]
				: rz[erv_pkg::COORD_WIDTH-1:0];
			sat_o <= hx | lx | hy | ly | hz | lz;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/euler_xyz_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotation
// Rotates a Q15.16 vector about X, then Y, then Z by three binary angles.
// ----------------------------------------------------------------------------
// One vector enters per clock and one result leaves per clock unless the
// output register is held. From an accepted input beat to its output beat,
// each of the three plane rotations takes one pre-rotation stage, one stage
// per CORDIC micro-rotation and two gain multiply stages, followed by one
// rounding/saturation output register. All stages advance together while
// the output register is empty or taken; a one-beat skid register at the
// input keeps s_tready registered and takes one more beat while the output
// is held.
`default_nettype none

`include "euler_xyz_vector_rotation_assert.svh"

module euler_xyz_vector_rotation (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// in_x[31:0], in_y[63:32], in_z[95:64], angle_about_x[111:96],
	// angle_about_y[127:112], angle_about_z[143:128]
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [95:0]       m_tdata,
	// saturated[0]
	output logic [0:0]        m_tuser
);

	logic           skid_vld_q;
	logic [143:0]   skid_data_q;
	logic           en;
	logic           pin_vld;
	logic [143:0]   pin_data;

	erv_pkg::acc_t  x0, y0, z0;
	erv_pkg::angle_t ang_x, ang_y, ang_z;

	logic           p1_vld, p2_vld, p3_vld;
	erv_pkg::acc_t  p1_u, p1_v, p1_w;
	erv_pkg::acc_t  p2_u, p2_v, p2_w;
	erv_pkg::acc_t  p3_u, p3_v, p3_w;
	erv_pkg::side_t p1_side, p2_side;

	logic signed [erv_pkg::COORD_WIDTH-1:0] ox, oy, oz;
	logic           osat;

	// Advance the whole pipeline while the output register can move
	assign en = !m_tvalid || m_tready;

	// Hold one beat while the pipeline is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_tvalid && s_tready) begin
			skid_data_q <= s_tdata;
		end
	end

	assign s_tready = !skid_vld_q;
	assign pin_vld  = skid_vld_q || (s_tvalid && s_tready);
	assign pin_data = skid_vld_q ? skid_data_q : s_tdata;

	// Unpack and add guard fraction bits
	assign x0 = erv_pkg::acc_t'($signed(pin_data[31:0])) <<< erv_pkg::GUARD_BITS;
	assign y0 = erv_pkg::acc_t'($signed(pin_data[63:32])) <<< erv_pkg::GUARD_BITS;
	assign z0 = erv_pkg::acc_t'($signed(pin_data[95:64])) <<< erv_pkg::GUARD_BITS;
	assign ang_x = pin_data[111:96];
	assign ang_y = pin_data[127:112];
	assign ang_z = pin_data[143:128];

	// Rotate about X: (y, z) plane
	erv_plane u_plane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (pin_vld),
		.u_i     (y0),
		.v_i     (z0),
		.w_i     (x0),
		.angle_i (ang_x),
		.side_i  ({ang_z, ang_y}),
		.vld_o   (p1_vld),
		.u_o     (p1_u),
		.v_o     (p1_v),
		.w_o     (p1_w),
		.side_o  (p1_side)
	);

	// Rotate about Y: (z, x) plane
	erv_plane u_plane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (p1_vld),
		.u_i     (p1_v),
		.v_i     (p1_w),
		.w_i     (p1_u),
		.angle_i (p1_side[erv_pkg::ANGLE_WIDTH-1:0]),
		.side_i  ({{erv_pkg::ANGLE_WIDTH{1'b0}}, p1_side[erv_pkg::SIDE_WIDTH-1:erv_pkg::ANGLE_WIDTH]}),
		.vld_o   (p2_vld),
		.u_o     (p2_u),
		.v_o     (p2_v),
		.w_o     (p2_w),
		.side_o  (p2_side)
	);

	// Rotate about Z: (x, y) plane
	erv_plane u_plane_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (p2_vld),
		.u_i     (p2_v),
		.v_i     (p2_w),
		.w_i     (p2_u),
		.angle_i (p2_side[erv_pkg::ANGLE_WIDTH-1:0]),
		.side_i  ({erv_pkg::SIDE_WIDTH{1'b0}}),
		.vld_o   (p3_vld),
		.u_o     (p3_u),
		.v_o     (p3_v),
		.w_o     (p3_w),
		.side_o  ()
	);

	// p3: u = x, v = y, w = z
	erv_round_sat u_round_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (p3_vld),
		.x_i    (p3_u),
		.y_i    (p3_v),
		.z_i    (p3_w),
		.vld_o  (m_tvalid),
		.x_o    (ox),
		.y_o    (oy),
		.z_o    (oz),
		.sat_o  (osat)
	);

	assign m_tdata = {oz, oy, ox};
	assign m_tuser = osat;

	// A held beat survives a stall
	`ERV_ASSERT_NEXT(a_skid_hold, clk, arst_n, skid_vld_q && !en, skid_vld_q)

	// The skid register fills only while the pipeline is stalled
	`ERV_ASSERT_NEXT(a_skid_fill, clk, arst_n, !skid_vld_q && en, !skid_vld_q)

	// A saturated result has at least one coordinate at a range limit
	`ERV_ASSERT_IMPL(a_sat_limit, clk, arst_n, m_tvalid && m_tuser[0],
		(ox == 32'sh7fffffff) || (ox == 32'sh80000000) ||
		(oy == 32'sh7fffffff) || (oy == 32'sh80000000) ||
		(oz == 32'sh7fffffff) || (oz == 32'sh80000000))

endmodule

`default_nettype wire

// ===== verif/euler_rotation_checker.sv =====
// ----------------------------------------------------------------------------
// euler_rotation_checker
// Watches both stream channels of the Euler XYZ rotator. Every accepted input
// beat is run through a bit-exact fixed-point CORDIC model (X, then Y, then Z
// plane rotation) and queued. Every accepted output beat is compared field by
// field against the oldest queued vector.
// ----------------------------------------------------------------------------
module euler_rotation_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// in_x, in_y, in_z (32 bits each), angle_about_x, _y, _z (16 bits each)
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z (32 bits each)
	input  logic [95:0]  m_tdata,
	// saturated
	input  logic [0:0]   m_tuser,
	output int           mismatches,
	output int           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import erv_pkg::*;

	typedef struct packed {
		logic        sat;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} rotated_vec_t;

	// atan(2^-i) in 2^32 units per turn
	localparam longint ATAN_TURN [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};
	localparam longint GAIN_INV_Q30 = 652032874;
	localparam longint COORD_MAX    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN    = -COORD_MAX - 1;

	rotated_vec_t expected_vecs[$];

	// floor(a * G / 2^30), with a wide product to avoid overflow
	function automatic longint apply_gain(input longint a);
		logic signed [95:0] prod;
		prod = a;
		prod = prod * GAIN_INV_Q30;
		return longint'(prod >>> 30);
	endfunction

	// Rotate (u, v) by a binary angle: quarter-turn pre-rotation, then CORDIC
	function automatic void rotate_plane(inout longint u, inout longint v,
			input logic [ANGLE_WIDTH-1:0] ang);
		logic [31:0] a32;
		logic [31:0] rem;
		quad_t       q;
		longint      w;
		longint      t;
		longint      du;
		longint      dv;
		a32 = 32'(ang) << (32 - ANGLE_WIDTH);
		q   = quad_t'((a32 + 32'h2000_0000) >> 30);
		rem = a32 - {q, 30'd0};
		w   = longint'($signed(rem));
		case (q)
			QUAD_1: begin
				t = u; u = -v; v = t;
			end
			QUAD_2: begin
				u = -u; v = -v;
			end
			QUAD_3: begin
				t = u; u = v; v = -t;
			end
			default: ;
		endcase
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			du = v >>> i;
			dv = u >>> i;
			if (w >= 0) begin
				u = u - du; v = v + dv; w = w - ATAN_TURN[i];
			end else begin
				u = u + du; v = v - dv; w = w + ATAN_TURN[i];
			end
		end
		u = apply_gain(u);
		v = apply_gain(v);
	endfunction

	// Round half up out of the guard bits, then clip to the coordinate range
	function automatic logic [31:0] round_clip(input longint a, inout logic sat);
		longint r;
		r = (a + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
		if (r > COORD_MAX) begin
			r = COORD_MAX; sat = 1'b1;
		end
		if (r < COORD_MIN) begin
			r = COORD_MIN; sat = 1'b1;
		end
		return 32'(r);
	endfunction

	function automatic rotated_vec_t rotate_xyz(input logic [143:0] d);
		longint       x;
		longint       y;
		longint       z;
		logic         sat;
		rotated_vec_t r;
		x   = longint'($signed(d[31:0])) <<< GUARD_BITS;
		y   = longint'($signed(d[63:32])) <<< GUARD_BITS;
		z   = longint'($signed(d[95:64])) <<< GUARD_BITS;
		sat = 1'b0;
		rotate_plane(y, z, d[111:96]);
		rotate_plane(z, x, d[127:112]);
		rotate_plane(x, y, d[143:128]);
		r.x   = round_clip(x, sat);
		r.y   = round_clip(y, sat);
		r.z   = round_clip(z, sat);
		r.sat = sat;
		return r;
	endfunction

	// Compare output beats first, then queue the new input beat
	always @(posedge clk) begin
		rotated_vec_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_vecs.size() == 0) begin
					$display("%0t: output beat with nothing expected, got %h sat %b",
						$time, m_tdata, m_tuser);
					mismatches = mismatches + 1;
				end else begin
					want = expected_vecs.pop_front();
					if (m_tdata[31:0] !== want.x) begin
						$display("%0t: out_x expected %h actual %h", $time, want.x,
							m_tdata[31:0]);
						mismatches = mismatches + 1;
					end
					if (m_tdata[63:32] !== want.y) begin
						$display("%0t: out_y expected %h actual %h", $time, want.y,
							m_tdata[63:32]);
						mismatches = mismatches + 1;
					end
					if (m_tdata[95:64] !== want.z) begin
						$display("%0t: out_z expected %h actual %h", $time, want.z,
							m_tdata[95:64]);
						mismatches = mismatches + 1;
					end
					if (m_tuser[0] !== want.sat) begin
						$display("%0t: saturated expected %b actual %b", $time, want.sat,
							m_tuser[0]);
						mismatches = mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_vecs.push_back(rotate_xyz(s_tdata));
		end
		outstanding = expected_vecs.size();
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Euler XYZ vector rotator. A directed set covers
// zero and extreme coordinates, all quadrants of the X and Z angles and three
// of Y, quadrant boundaries and clipping; then random vectors run in three
// phases of sender/receiver idling, with long receiver hold-offs and drains.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_BEATS    = 567;
	localparam int HOLD_OFF_CYCLS = 200;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] C_MIN = 32'h8000_0000;
	localparam logic [31:0] C_ONE = 32'h0001_0000;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;

	int mismatches;
	int outstanding;
	int src_idle_pct;
	int snk_idle_pct;
	int quiet_cycles;
	logic hold_off;

	euler_xyz_vector_rotation i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	euler_rotation_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			quiet_cycles = quiet_cycles + 1;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("euler_xyz_vector_rotation: mismatch");
			$finish;
		end
	end

	// Receiver: random backpressure, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready = 1'b0;
				repeat (HOLD_OFF_CYCLS) @(negedge clk);
				hold_off = 1'b0;
			end
			m_tready = ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Offer one beat, idling first at random, and hold it until accepted
	task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {az, ay, ax, z, y, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every queued vector has come out
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		logic [31:0] r;
		case ($urandom_range(7))
			4, 5: r = 32'($urandom_range(32'h0020_0000) - 32'h0010_0000);
			6: begin
				case ($urandom_range(4))
					0: r = C_MAX;
					1: r = C_MIN;
					2: r = '0;
					3: r = 32'd1;
					default: r = '1;
				endcase
			end
			7: r = 32'($urandom_range(32'h2000_0000) - 32'h1000_0000);
			default: r = $urandom();
		endcase
		return r;
	endfunction

	function automatic logic [15:0] pick_angle();
		logic [15:0] r;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(9))
				0: r = 16'h0000;
				1: r = 16'h1FFF;
				2: r = 16'h2000;
				3: r = 16'h4000;
				4: r = 16'h6000;
				5: r = 16'h8000;
				6: r = 16'hA000;
				7: r = 16'hC000;
				8: r = 16'hE000;
				default: r = 16'hFFFF;
			endcase
		end else begin
			r = 16'($urandom());
		end
		return r;
	endfunction

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		hold_off     = 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero, extremes, quadrants, quadrant edges, clipping
		send_vector('0, '0, '0, 16'h0000, 16'h0000, 16'h0000);
		send_vector(32'd1, '0, '0, 16'h0000, 16'h0000, 16'h0000);
		send_vector(C_MAX, C_MIN, '1, 16'h0000, 16'h0000, 16'h0000);
		send_vector(C_ONE, '0, '0, 16'h0000, 16'h0000, 16'h4000);
		send_vector(C_ONE, '0, '0, 16'h0000, 16'h0000, 16'h8000);
		send_vector(C_ONE, '0, '0, 16'h0000, 16'h0000, 16'hC000);
		send_vector('0, C_ONE, '0, 16'h4000, 16'h0000, 16'h0000);
		send_vector('0, '0, C_ONE, 16'h0000, 16'h4000, 16'h0000);
		send_vector(C_ONE, C_ONE, C_ONE, 16'h2000, 16'h2000, 16'h2000);
		send_vector(C_ONE, C_ONE, C_ONE, 16'h1FFF, 16'h1FFF, 16'h1FFF);
		send_vector(C_ONE, C_ONE, C_ONE, 16'hDFFF, 16'hE000, 16'hDFFF);
		send_vector(C_MAX, C_MAX, C_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_vector(C_MAX, C_MAX, C_MAX, 16'h2000, 16'h2000, 16'h2000);
		send_vector(C_MIN, C_MIN, C_MIN, 16'h2000, 16'h2000, 16'h2000);
		send_vector(C_MIN, C_MIN, C_MIN, 16'h0000, 16'h0000, 16'h0000);
		send_vector('1, '1, '1, 16'h8000, 16'h8000, 16'h8000);
		send_vector(C_MIN, '0, '0, 16'h0000, 16'h0000, 16'h8000);
		send_vector('0, C_MIN, C_MAX, 16'h8000, 16'h4000, 16'hC000);
		send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
			16'hAAAA, 16'h5555, 16'h1234);
		send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A987,
			16'h7FFF, 16'h8001, 16'h0001);
		drain_results();

		// Random: three idling phases, hold-off in the first and last
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 23; snk_idle_pct = 74;
				end
				1: begin
					src_idle_pct = 74; snk_idle_pct = 23;
				end
				default: begin
					src_idle_pct = 0; snk_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if ((phase == 0 && n == 150) || (phase == 2 && n == 100))
					hold_off = 1'b1;
				if (phase == 1 && n == 300)
					drain_results();
				send_vector(pick_coord(), pick_coord(), pick_coord(),
					pick_angle(), pick_angle(), pick_angle());
			end
			drain_results();
		end

		// Let any stray output beat show up before the verdict
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("euler_xyz_vector_rotation: match");
		else
			$display("euler_xyz_vector_rotation: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/erv_pkg.sv
rtl/core/erv_gain.sv
rtl/core/erv_plane.sv
rtl/core/erv_round_sat.sv
rtl/core/euler_xyz_vector_rotation.sv
verif/euler_rotation_checker.sv
verif/tb_top.sv
